// File: rtl/hsi_pkg.sv
`default_nettype none

package hsi_pkg;

    // Fraction bits of the sector ratio t
    localparam int RATIO_FRAC_BITS = 14;
    localparam int RATIO_W         = RATIO_FRAC_BITS + 2;      // t never exceeds 3.0
    localparam int SECTOR_DEG      = 120;
    localparam int FULL_DEG        = 360;
    localparam int PCT_MAX         = 100;

    // Widths of the arithmetic chain
    localparam int PCT_W   = 7;
    localparam int HUE_W   = 9;
    localparam int OFS_W   = 7;                                // offset in sector, 0..119
    localparam int SI_W    = 14;                               // S*I <= 10000
    localparam int PROD_W  = SI_W + RATIO_W;                   // S*I*t
    localparam int LVLN_W  = 22;                               // numerators before /10000
    localparam int LEVEL_W = 8;

    // floor(y / 10000) = (y * RECIP_MUL) >> RECIP_SHIFT, exact for y < 2^22
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 23'd6871948;
    localparam int QUOT_W      = LVLN_W + RECIP_W;

    localparam logic [RATIO_W-1:0] RATIO_TOP = RATIO_W'(3) << RATIO_FRAC_BITS;
    localparam logic [7:0] CH_SCALE    = 8'd85;
    localparam logic [7:0] WHITE_SCALE = 8'd255;

    // Which two channels are active
    typedef enum logic [1:0] {
        SECT_RG = 2'd0,   // red first, green second
        SECT_GB = 2'd1,   // green first, blue second
        SECT_BR = 2'd2    // blue first, red second
    } sector_t;

    // Stage 1 -> stage 2
    typedef struct packed {
        sector_t           sector;
        logic [OFS_W-1:0]  offset;
        logic [PCT_W-1:0]  sat;
        logic [PCT_W-1:0]  inten;
    } prep_t;

    // Stage 2 -> stage 3
    typedef struct packed {
        sector_t            sector;
        logic [RATIO_W-1:0] t_first;
        logic [RATIO_W-1:0] t_second;
        logic [SI_W-1:0]    si;        // S*I
        logic [SI_W-1:0]    ni;        // (100-S)*I
    } ratio_t;

    typedef logic [RATIO_W-1:0] ratio_tab_t [0:SECTOR_DEG-1];

    // Unsigned restoring division, used only for the table math at elaboration
    function automatic longint unsigned div_u64(input longint unsigned dividend,
                                                input longint unsigned divisor);
        longint unsigned quo, rem;
        int              i;
        quo = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], dividend[i]};
            if (rem >= divisor) begin
                rem    = rem - divisor;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sector ratio table t = 1 + cos h / cos(60-h), evaluated at elaboration
    // with the fixed-point Taylor series of the color math.
    function automatic ratio_tab_t build_ratio_table();
        ratio_tab_t          tab;
        longint unsigned     x, x2, ct, st, t, top, a;
        longint              c, s, rs, num, den;
        int                  h, k;
        top = longint'(3) << RATIO_FRAC_BITS;
        for (h = 0; h < SECTOR_DEG; h++) begin
            a  = (h <= 90) ? longint'(h) : longint'(180 - h);
            x  = div_u64(a * 64'd3373259426 + 64'd90, 64'd180);
            x2 = (x * x) >> 30;
            ct = 64'd1073741824;
            st = x;
            c  = 64'sd1073741824;
            s  = longint'(x);
            for (k = 1; k <= 11; k++) begin
                ct = div_u64((ct * x2) >> 30, 64'((2*k - 1) * (2*k)));
                st = div_u64((st * x2) >> 30, 64'((2*k) * (2*k + 1)));
                if ((k & 1) == 1) begin
                    c = c - longint'(ct);
                    s = s - longint'(st);
                end else begin
                    c = c + longint'(ct);
                    s = s + longint'(st);
                end
            end
            if (h > 90) c = -c;
            if (s < 0) s = 0;
            rs  = longint'((longint'(s) * 64'd1859775393) >> 30);
            num = 3 * c + rs;
            den = c + rs;
            if (den <= 0 || num < 0) begin
                t = 0;
            end else begin
                t = div_u64((longint'(num) << RATIO_FRAC_BITS) + (longint'(den) >> 1),
                            longint'(den));
            end
            if (t > top) t = top;
            tab[h] = t[RATIO_W-1:0];
        end
        return tab;
    endfunction

    localparam ratio_tab_t RATIO_TABLE = build_ratio_table();

endpackage

`default_nettype wire

// File: rtl/hsi_prep.sv
`default_nettype none

// Stage 1: hue wrap, sector select, percent clamp
module hsi_prep import hsi_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [HUE_W-1:0] in_hue,
    input  wire logic [PCT_W-1:0] in_sat,
    input  wire logic [PCT_W-1:0] in_inten,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output prep_t                 out_data
);

    logic             valid_reg;
    prep_t            data_reg;
    prep_t            data_next;
    logic [HUE_W-1:0] hue_wrap;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // hue modulo 360 (input is below 512), then sector and offset
    always_comb begin
        hue_wrap = (in_hue >= HUE_W'(FULL_DEG)) ? in_hue - HUE_W'(FULL_DEG) : in_hue;
        if (hue_wrap < HUE_W'(SECTOR_DEG)) begin
            data_next.sector = SECT_RG;
            data_next.offset = hue_wrap[OFS_W-1:0];
        end else if (hue_wrap < HUE_W'(2 * SECTOR_DEG)) begin
            data_next.sector = SECT_GB;
            data_next.offset = OFS_W'(hue_wrap - HUE_W'(SECTOR_DEG));
        end else begin
            data_next.sector = SECT_BR;
            data_next.offset = OFS_W'(hue_wrap - HUE_W'(2 * SECTOR_DEG));
        end
        data_next.sat   = (in_sat > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_sat;
        data_next.inten = (in_inten > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_inten;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hsi_ratio.sv
`default_nettype none

// Stage 2: ratio table lookup and percent products
module hsi_ratio import hsi_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire prep_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output ratio_t    out_data
);

    logic               valid_reg;
    ratio_t             data_reg;
    ratio_t             data_next;
    logic [RATIO_W-1:0] t_lookup;
    logic [PCT_W-1:0]   unsat;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        t_lookup            = RATIO_TABLE[in_data.offset];
        unsat               = PCT_W'(PCT_MAX) - in_data.sat;
        data_next.sector    = in_data.sector;
        data_next.t_first   = t_lookup;
        data_next.t_second  = RATIO_TOP - t_lookup;
        data_next.si        = SI_W'(in_data.sat) * SI_W'(in_data.inten);
        data_next.ni        = SI_W'(unsat) * SI_W'(in_data.inten);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hsi_level.sv
`default_nettype none

// Stages 3..5: level products, divide by 10000, channel routing
module hsi_level import hsi_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ratio_t             in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [4*LEVEL_W-1:0]    out_levels
);

    // stage 3 registers: S*I*t products and white numerator
    logic              v3_reg;
    sector_t           sect3_reg;
    logic [PROD_W-1:0] p1_reg, p2_reg;
    logic [LVLN_W-1:0] w3_reg;
    // stage 4 registers: numerators of the final divide
    logic              v4_reg;
    sector_t           sect4_reg;
    logic [LVLN_W-1:0] y1_reg, y2_reg, w4_reg;
    // stage 5: output register
    logic               v5_reg;
    logic [LEVEL_W-1:0] red_reg, green_reg, blue_reg, white_reg;
    logic [LEVEL_W-1:0] red_next, green_next, blue_next, white_next;

    logic rdy3, rdy4, rdy5;
    logic [PROD_W+7:0]  y1_full, y2_full;
    logic [QUOT_W-1:0]  q1_full, q2_full, qw_full;
    logic [LEVEL_W-1:0] q1, q2;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    assign out_valid  = v5_reg;
    assign out_levels = {white_reg, blue_reg, green_reg, red_reg};

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy3) v3_reg <= in_valid;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 3: S*I times the two ratios, white numerator 255*(100-S)*I
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            sect3_reg <= in_data.sector;
            p1_reg    <= PROD_W'(in_data.si) * PROD_W'(in_data.t_first);
            p2_reg    <= PROD_W'(in_data.si) * PROD_W'(in_data.t_second);
            w3_reg    <= LVLN_W'(in_data.ni) * LVLN_W'(WHITE_SCALE);
        end
    end

    // stage 4: times 85, drop the ratio fraction
    assign y1_full = (PROD_W+8)'(p1_reg) * (PROD_W+8)'(CH_SCALE);
    assign y2_full = (PROD_W+8)'(p2_reg) * (PROD_W+8)'(CH_SCALE);

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            sect4_reg <= sect3_reg;
            y1_reg    <= y1_full[RATIO_FRAC_BITS +: LVLN_W];
            y2_reg    <= y2_full[RATIO_FRAC_BITS +: LVLN_W];
            w4_reg    <= w3_reg;
        end
    end

    // stage 5: divide by 10000 through reciprocal multiply, route channels
    always_comb begin
        q1_full    = QUOT_W'(y1_reg) * QUOT_W'(RECIP_MUL);
        q2_full    = QUOT_W'(y2_reg) * QUOT_W'(RECIP_MUL);
        qw_full    = QUOT_W'(w4_reg) * QUOT_W'(RECIP_MUL);
        q1         = q1_full[RECIP_SHIFT +: LEVEL_W];
        q2         = q2_full[RECIP_SHIFT +: LEVEL_W];
        white_next = qw_full[RECIP_SHIFT +: LEVEL_W];
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        unique case (sect4_reg)
            SECT_RG: begin
                red_next   = q1;
                green_next = q2;
            end
            SECT_GB: begin
                green_next = q1;
                blue_next  = q2;
            end
            SECT_BR: begin
                blue_next  = q1;
                red_next   = q2;
            end
            default: begin
                red_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            white_reg <= white_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hsi_to_rgbw_converter_unit.sv
`default_nettype none

// HSI to RGBW color converter. Takes one color item per clock (hue in whole
// degrees, wrapped modulo 360; saturation and intensity in percent, clamped at
// 100) and returns four 8-bit drive levels. Five register stages: hue/sector
// and clamp, ratio table lookup with S*I products, ratio multiply, scale by 85,
// and a reciprocal-multiply divide by 10000 into the output register. The
// result is registered through each of these stages before it shows on
// m_tvalid; throughput is one item per clock as long as m_tready stays high.
// Each stage holds its item while the next is full, so a stalled output
// fills the pipe with five items before s_tready drops. The 120-entry sector
// ratio table is a constant built at elaboration.
module hsi_to_rgbw_converter_unit import hsi_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [8:0] hue_deg, [15:9] saturation_pct, [22:16] intensity_pct, [23] zero
    input  wire logic [23:0] s_tdata,
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] red_level, [15:8] green_level, [23:16] blue_level, [31:24] white_level
    output logic [31:0]      m_tdata
);

    logic   prep_valid, prep_ready;
    prep_t  prep_data;
    logic   ratio_valid, ratio_ready;
    ratio_t ratio_data;

    hsi_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_hue    (s_tdata[8:0]),
        .in_sat    (s_tdata[15:9]),
        .in_inten  (s_tdata[22:16]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    hsi_ratio u_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (ratio_valid),
        .out_ready (ratio_ready),
        .out_data  (ratio_data)
    );

    hsi_level u_level (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (ratio_valid),
        .in_ready   (ratio_ready),
        .in_data    (ratio_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_levels (m_tdata)
    );

endmodule

`default_nettype wire

// File: tb/hsi_to_rgbw_converter_unit_tb.sv
module hsi_to_rgbw_converter_unit_tb;
    import hsi_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;

    // One colour as it sits in s_tdata, lowest field last
    typedef struct packed {
        logic [6:0] inten;
        logic [6:0] sat;
        logic [8:0] hue;
    } colour_in_t;

    // Four drive levels as they sit in m_tdata, red lowest
    typedef struct packed {
        logic [7:0] white;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgbw_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    colour_in_t colours_pending[$];
    rgbw_t      levels_due[$];

    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;
    bit hold_go     = 1'b0;
    bit hold_done   = 1'b0;
    int hold_count  = 0;

    int mismatches     = 0;
    int colours_taken  = 0;
    int levels_checked = 0;
    int input_stalls   = 0;

    hsi_to_rgbw_converter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // t = 1 + cos h / cos(60 - h) for an offset inside a sector, fixed point,
    // sin/cos from a Q30 Taylor series
    function automatic longint unsigned sector_ratio_fx(input int offset);
        longint unsigned ang, x, x2, c_term, s_term, t, t_top;
        longint          c_sum, s_sum, root3_s, num, den;
        int              k;
        ang = (offset <= 90) ? offset : 180 - offset;
        x   = (ang * 64'd3373259426 + 64'd90) / 64'd180;
        x2  = (x * x) >> 30;
        c_term = 64'd1 << 30;
        s_term = x;
        c_sum  = 64'sd1 << 30;
        s_sum  = $signed(x);
        for (k = 1; k <= 11; k++) begin
            c_term = ((c_term * x2) >> 30) / ((2 * k - 1) * (2 * k));
            s_term = ((s_term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                c_sum = c_sum - $signed(c_term);
                s_sum = s_sum - $signed(s_term);
            end else begin
                c_sum = c_sum + $signed(c_term);
                s_sum = s_sum + $signed(s_term);
            end
        end
        // past 90 degrees fold back, cosine changes sign
        if (offset > 90) c_sum = -c_sum;
        if (s_sum < 0) s_sum = 0;
        root3_s = $signed(($unsigned(s_sum) * 64'd1859775393) >> 30);
        num = 3 * c_sum + root3_s;
        den = c_sum + root3_s;
        if (den <= 0 || num < 0) return 0;
        t = (($unsigned(num) << RATIO_FRAC_BITS) + ($unsigned(den) >> 1)) / $unsigned(den);
        t_top = 64'd3 << RATIO_FRAC_BITS;
        return (t > t_top) ? t_top : t;
    endfunction

    function automatic rgbw_t rgbw_levels(input colour_in_t c);
        rgbw_t           lv;
        int              hue;
        longint unsigned sat, inten, t, scale, dv, first, second;
        hue   = c.hue % FULL_DEG;
        sat   = (c.sat > PCT_MAX) ? PCT_MAX : c.sat;
        inten = (c.inten > PCT_MAX) ? PCT_MAX : c.inten;
        t      = sector_ratio_fx(hue % SECTOR_DEG);
        scale  = sat * inten * 85;
        dv     = 64'd10000 << RATIO_FRAC_BITS;
        first  = (scale * t) / dv;
        second = (scale * ((64'd3 << RATIO_FRAC_BITS) - t)) / dv;
        lv = '0;
        lv.white = 8'((255 * (100 - sat) * inten) / 10000);
        case (sector_t'(hue / SECTOR_DEG))
            SECT_RG: begin
                lv.red   = 8'(first);
                lv.green = 8'(second);
            end
            SECT_GB: begin
                lv.green = 8'(first);
                lv.blue  = 8'(second);
            end
            SECT_BR: begin
                lv.blue = 8'(first);
                lv.red  = 8'(second);
            end
            default: ;
        endcase
        return lv;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got, want);
        $display("mismatch in %s of result %0d: got %0d, expected %0d",
                 field, levels_checked, got, want);
        mismatches++;
    endtask

    // Driver: offer the next pending colour, idling now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (colours_pending.size() != 0 && (send_steady || $urandom_range(99) >= 18)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= 24'(colours_pending.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else begin
            m_tready <= recv_steady || ($urandom_range(99) >= 18);
        end
    end

    // Monitor: predict on input accept, check on output accept
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                levels_due.push_back(rgbw_levels(colour_in_t'(s_tdata[22:0])));
                colours_taken++;
            end
            if (s_tvalid && !s_tready) input_stalls++;
            if (m_tvalid && m_tready) begin
                if (levels_due.size() == 0) begin
                    $display("unexpected result item %08h", m_tdata);
                    mismatches++;
                end else begin
                    rgbw_t want, got;
                    want = levels_due.pop_front();
                    got  = rgbw_t'(m_tdata);
                    if (got.red !== want.red) report_mismatch("red", got.red, want.red);
                    if (got.green !== want.green)
                        report_mismatch("green", got.green, want.green);
                    if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
                    if (got.white !== want.white)
                        report_mismatch("white", got.white, want.white);
                end
                levels_checked++;
            end
        end
    end

    task automatic add_colour(input int hue, input int sat, input int inten);
        colour_in_t c;
        c.hue   = 9'(hue);
        c.sat   = 7'(sat);
        c.inten = 7'(inten);
        colours_pending.push_back(c);
    endtask

    // Percent value: mostly legal, with the ends and the clamped range mixed in
    function automatic int pick_pct();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 20) return 100;
        if (r < 80) return $urandom_range(100);
        return $urandom_range(127);
    endfunction

    task automatic add_random(input int count);
        int n, hue;
        for (n = 0; n < count; n++) begin
            hue = ($urandom_range(99) < 85) ? $urandom_range(359) : $urandom_range(511);
            add_colour(hue, pick_pct(), pick_pct());
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (colours_pending.size() != 0 || s_tvalid || levels_due.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // sector edges, hue wrap, clamping, zero saturation and intensity
        add_colour(0, 100, 100);
        add_colour(59, 100, 100);
        add_colour(60, 100, 100);
        add_colour(90, 100, 100);
        add_colour(91, 100, 100);
        add_colour(119, 100, 100);
        add_colour(120, 100, 100);
        add_colour(180, 50, 80);
        add_colour(239, 100, 100);
        add_colour(240, 100, 100);
        add_colour(300, 75, 60);
        add_colour(359, 100, 100);
        add_colour(360, 100, 100);
        add_colour(511, 127, 127);
        add_colour(0, 0, 100);
        add_colour(200, 0, 0);
        add_colour(45, 101, 127);
        add_colour(150, 127, 50);
        add_colour(270, 100, 0);
        add_colour(30, 0, 127);
        add_colour(330, 1, 1);
        add_colour(100, 100, 101);
        wait_drained();

        // back-to-back stretch, no idling on either side
        send_steady = 1'b1;
        recv_steady = 1'b1;
        add_random(500);
        wait_drained();
        recv_steady = 1'b0;

        // long output hold-off while input keeps coming
        add_random(300);
        while (colours_pending.size() > 290) @(negedge aclk);
        hold_go = 1'b1;
        while (!hold_done) @(negedge aclk);
        send_steady = 1'b0;
        wait_drained();

        // random idling on both sides
        add_random(1200);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("%0d colours sent, %0d results checked, %0d mismatches",
                 colours_taken, levels_checked, mismatches);
        $display("input held off for %0d cycles by output back-pressure", input_stalls);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("timeout with %0d results outstanding", levels_due.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/hsi_pkg.sv
rtl/hsi_prep.sv
rtl/hsi_ratio.sv
rtl/hsi_level.sv
rtl/hsi_to_rgbw_converter_unit.sv
tb/hsi_to_rgbw_converter_unit_tb.sv
